// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by indexed_ordered_list_unit.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Antecedent this cycle implies consequent on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/iol_pkg.sv -----
// Package for the indexed ordered list unit: action and status codes,
// cell command type. No dependencies.
`default_nettype none

package iol_pkg;

   localparam logic [2:0] ACT_GET    = 3'd0;
   localparam logic [2:0] ACT_HEAD   = 3'd1;
   localparam logic [2:0] ACT_TAIL   = 3'd2;
   localparam logic [2:0] ACT_INSERT = 3'd3;
   localparam logic [2:0] ACT_DELETE = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [WORD_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/iol_cell.sv -----
// One list slot: holds an entry, shifts from its neighbors on insert/remove.
// Depends on iol_pkg.
`default_nettype none

module iol_cell #(
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  wire logic                       clock,
   input  wire iol_pkg::cell_cmd_type      cmd,
   input  wire logic [IW-1:0]              pos,
   input  wire logic [iol_pkg::WORD_W-1:0] left_value,
   input  wire logic [iol_pkg::WORD_W-1:0] right_value,
   output logic      [iol_pkg::WORD_W-1:0] entry_value,
   output logic      [iol_pkg::WORD_W-1:0] tap_value
);
   import iol_pkg::*;

   localparam logic [IW-1:0] SLOT = IW'(INDEX);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;
   logic              hit;
   logic              above;

   assign hit   = (pos == SLOT);
   assign above = (SLOT > pos);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (above) begin
               entry_in = left_value;
            end else if (hit) begin
               entry_in = cmd.value;
            end
         end
         CELL_REMOVE: begin
            if (above || hit) begin
               entry_in = right_value;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign tap_value   = hit ? entry_ff : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_ordered_list_unit.sv -----
// Top level of the indexed ordered list: decode, length count, cell row.
// Depends on iol_pkg, iol_cell and assert_macros.svh.
//
//   channel   ports                         handshake
//   request   req_action/position/item_value start, busy (accepted: start & !busy)
//   response  rsp_read_value/status/length_now rsp_strobe, one cycle, no stall
//
// One word per cycle; the response appears on the cycle after acceptance.
// All cells shift in the same edge, so busy stays low.
// Get reads through a per-cell tap and an OR over the row.
// Synchronous reset clears the length count and the strobe; slots are not cleared.
`default_nettype none
`include "assert_macros.svh"

module indexed_ordered_list_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic        [2:0]                 req_action,
   input  wire logic signed [15:0]                req_position,
   input  wire logic signed [iol_pkg::WORD_W-1:0] req_item_value,
   output logic                                   rsp_strobe,
   output logic signed      [iol_pkg::WORD_W-1:0] rsp_read_value,
   output logic             [1:0]                 rsp_status,
   output logic             [$clog2(CAPACITY + 1)-1:0] rsp_length_now
);
   import iol_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [CW-1:0]     count_ff, count_in;
   logic              strobe_ff, strobe_in;
   logic [WORD_W-1:0] read_ff, read_in;
   logic [1:0]        status_ff, status_in;

   cell_cmd_type      cmd;
   logic [IW-1:0]     cell_pos;
   logic [WORD_W-1:0] entry [CAPACITY];
   logic [WORD_W-1:0] tap   [CAPACITY];
   logic [WORD_W-1:0] tap_or;

   logic              accept;
   logic              full;
   logic [15:0]       pos_raw;
   logic [15:0]       ins_pos;
   logic [15:0]       count_wide;
   logic              idx_ok;
   logic              ins_ok;
   logic              full_rsp_ok;

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign full       = (count_ff == CAP_COUNT);
   assign pos_raw    = req_position;
   assign count_wide = 16'(count_ff);
   assign idx_ok     = !req_position[15] && (pos_raw < count_wide);
   assign ins_pos    = req_position[15] ? 16'd0 : pos_raw;
   assign ins_ok     = (ins_pos <= count_wide);

   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | tap[i];
      end
   end

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.value = req_item_value;
      cell_pos  = pos_raw[IW-1:0];
      read_in   = '0;
      status_in = ST_DONE;
      count_in  = count_ff;
      case (req_action)
         ACT_GET: begin
            if (idx_ok) begin
               read_in = tap_or;
            end else begin
               read_in   = '1;
               status_in = ST_RANGE;
            end
         end
         ACT_HEAD: begin
            cell_pos = '0;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_TAIL: begin
            cell_pos = count_ff[IW-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            cell_pos = ins_pos[IW-1:0];
            if (!ins_ok) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_DELETE: begin
            if (idx_ok) begin
               cmd.op   = CELL_REMOVE;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            cmd.op = CELL_HOLD;
         end
      endcase
      if (!accept) begin
         cmd.op   = CELL_HOLD;
         count_in = count_ff;
      end
   end

   assign strobe_in = accept;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] right_value;
      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_r
         assign right_value = entry[g+1];
      end
      iol_cell #(
         .IW    (IW),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (cell_pos),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_value (entry[g]),
         .tap_value   (tap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      read_ff   <= read_in;
      status_ff <= status_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = read_ff;
   assign rsp_status     = status_ff;
   assign rsp_length_now = count_ff;

   assign full_rsp_ok = !rsp_strobe || rsp_status != ST_FULL || rsp_length_now == CAP_COUNT;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CAP_COUNT, "length count above capacity")
   `ASSERT_NEXT(a_word_answered, accept, rsp_strobe, "accepted word got no response")
   `ASSERT_ALWAYS(a_full_len, full_rsp_ok, "full status with room left")
   `ASSERT_NEXT(a_count_idle, !accept, $stable(count_ff), "length changed without a word")

endmodule

`default_nettype wire
